// ===== src/mbpr_pkg.sv =====
// ----------------------------------------------------------------------------
// mbpr_pkg
// Shared types and constants for the MPEG block pixel reconstruction pipeline.
// ----------------------------------------------------------------------------
package mbpr_pkg;

	// Field widths
	localparam int BLK_W    = 4;
	localparam int COORD_W  = 12;
	localparam int POS_W    = 3;
	localparam int RES_W    = 16;
	localparam int PIX_W    = 8;
	localparam int PLANE_W  = 2;
	localparam int ADDR_W   = 24;
	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CF_W     = 2;

	// Line index and horizontal offset: 4095 + 8 + 7 at most
	localparam int LINE_W   = 13;
	localparam int XSUM_W   = 13;

	// Intra blocks are level shifted by this amount
	localparam logic [PIX_W-1:0] INTRA_OFFSET = 8'd128;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIELD_PICTURE   = 2'd0,
		REG_CHROMA_SAMPLING = 2'd1,
		REG_LUMA_WIDTH      = 2'd2,
		REG_CHROMA_WIDTH    = 2'd3
	} cfg_reg_t;

	// Chroma sampling formats
	localparam logic [CF_W-1:0] CF_420 = 2'd0;
	localparam logic [CF_W-1:0] CF_422 = 2'd1;
	localparam logic [CF_W-1:0] CF_444 = 2'd2;

	// Target planes
	localparam logic [PLANE_W-1:0] PLANE_Y  = 2'd0;
	localparam logic [PLANE_W-1:0] PLANE_CB = 2'd1;
	localparam logic [PLANE_W-1:0] PLANE_CR = 2'd2;

	// Reset values of the line widths
	localparam logic [CFG_W-1:0] LUMA_WIDTH_RST   = 13'd720;
	localparam logic [CFG_W-1:0] CHROMA_WIDTH_RST = 13'd360;

	// Address terms produced by the decode stage
	typedef struct packed {
		logic [PLANE_W-1:0] plane;
		logic               dbl_width;  // line pitch is twice the width
		logic [LINE_W-1:0]  line;       // line index within the plane
		logic [XSUM_W-1:0]  xsum;       // column within the plane
	} addr_terms_t;

endpackage

// ===== src/mbpr_decode.sv =====
// ----------------------------------------------------------------------------
// mbpr_decode
// Block position decode: plane, line width, line index and column of a pixel.
// ----------------------------------------------------------------------------
module mbpr_decode #(
	parameter int MAX_WIDTH = 4096,
	parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
	input  logic [mbpr_pkg::BLK_W-1:0]   block_number,
	input  logic [mbpr_pkg::COORD_W-1:0] origin_x,
	input  logic [mbpr_pkg::COORD_W-1:0] origin_y,
	input  logic                         dct_field,
	input  logic [mbpr_pkg::POS_W-1:0]   row,
	input  logic [mbpr_pkg::POS_W-1:0]   column,
	input  logic                         field_picture,
	input  logic [mbpr_pkg::CF_W-1:0]    chroma_sampling,
	input  logic [mbpr_pkg::CFG_W-1:0]   luma_width,
	input  logic [mbpr_pkg::CFG_W-1:0]   chroma_line_width,
	output mbpr_pkg::addr_terms_t        terms,
	output logic [WW-1:0]                width
);

	localparam logic [WW-1:0] WMAX = WW'(MAX_WIDTH);

	logic                         luma;
	logic                         interleave;
	logic [mbpr_pkg::CFG_W-1:0]   w_raw;
	logic [mbpr_pkg::COORD_W-1:0] bx;
	logic [mbpr_pkg::COORD_W-1:0] by;
	logic [3:0]                   xoff;
	logic [3:0]                   yoff;
	logic [3:0]                   rowoff;

	always_comb begin
		luma  = (block_number[3:2] == 2'b00);
		w_raw = luma ? luma_width : chroma_line_width;
		// saturate the line width
		if ((mbpr_pkg::CFG_W + 1)'(w_raw) > (mbpr_pkg::CFG_W + 1)'(MAX_WIDTH)) begin
			width = WMAX;
		end else begin
			width = WW'(w_raw);
		end

		// chroma subsampling of the origin
		bx = origin_x;
		by = origin_y;
		if (!luma && chroma_sampling != mbpr_pkg::CF_444) bx = {1'b0, origin_x[11:1]};
		if (!luma && chroma_sampling == mbpr_pkg::CF_420) by = {1'b0, origin_y[11:1]};

		if (luma) begin
			terms.plane = mbpr_pkg::PLANE_Y;
			xoff        = {block_number[0], 3'b000};
			interleave  = !field_picture && dct_field;
		end else begin
			terms.plane = block_number[0] ? mbpr_pkg::PLANE_CR : mbpr_pkg::PLANE_CB;
			xoff        = {block_number[3], 3'b000};
			interleave  = !field_picture && dct_field &&
			              (chroma_sampling != mbpr_pkg::CF_420);
		end

		// field DCT: blocks interleave on alternate lines
		if (interleave) begin
			yoff   = {3'b000, block_number[1]};
			rowoff = {row, 1'b0};
		end else begin
			yoff   = {block_number[1], 3'b000};
			rowoff = {1'b0, row};
		end

		terms.dbl_width = field_picture;
		terms.line = mbpr_pkg::LINE_W'(by) + mbpr_pkg::LINE_W'(yoff) +
		             mbpr_pkg::LINE_W'(rowoff);
		terms.xsum = mbpr_pkg::XSUM_W'(bx) + mbpr_pkg::XSUM_W'(xoff) +
		             mbpr_pkg::XSUM_W'(column);
	end

endmodule

// ===== src/mbpr_pixel.sv =====
// ----------------------------------------------------------------------------
// mbpr_pixel
// Residual add with prediction or intra offset, clipped to 0..255.
// ----------------------------------------------------------------------------
module mbpr_pixel (
	input  logic signed [mbpr_pkg::RES_W-1:0] residual,
	input  logic [mbpr_pkg::PIX_W-1:0]        prediction,
	input  logic                              add_mode,
	output logic [mbpr_pkg::PIX_W-1:0]        pixel
);

	logic [mbpr_pkg::PIX_W-1:0]          base;
	logic signed [mbpr_pkg::RES_W:0]     sum;

	always_comb begin
		base = add_mode ? prediction : mbpr_pkg::INTRA_OFFSET;
		sum  = (mbpr_pkg::RES_W + 1)'(residual) +
		       $signed({{(mbpr_pkg::RES_W + 1 - mbpr_pkg::PIX_W){1'b0}}, base});
		// clip to pixel range
		if (sum[mbpr_pkg::RES_W]) begin
			pixel = '0;
		end else if (sum[mbpr_pkg::RES_W-1:mbpr_pkg::PIX_W] != '0) begin
			pixel = '1;
		end else begin
			pixel = sum[mbpr_pkg::PIX_W-1:0];
		end
	end

endmodule

// ===== src/mpeg_block_pixel_reconstruct.sv =====
// ----------------------------------------------------------------------------
// mpeg_block_pixel_reconstruct
// MPEG-1/2 per-pixel block reconstruction: frame address and add/clip.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock and returns one result per clock while
// the output is not stalled. A request passes through three register stages
// and its result leaves the output register when the output is not stalled.
// Stage 1 decodes the block position and forms the clipped pixel, stage 2
// holds the single pitch-by-line multiplier, stage 3 adds the column and
// registers the output. Stalls fill pipeline bubbles first, so input is
// still taken while a result waits at the output. Configuration is to be
// written by the user only while idle; the block does not enforce this.
module mpeg_block_pixel_reconstruct #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [mbpr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mbpr_pkg::CFG_W-1:0]           cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mbpr_pkg::BLK_W-1:0]           block_number,
	input  logic [mbpr_pkg::COORD_W-1:0]         origin_x,
	input  logic [mbpr_pkg::COORD_W-1:0]         origin_y,
	input  logic                                 dct_field,
	input  logic                                 add_mode,
	input  logic [mbpr_pkg::POS_W-1:0]           row,
	input  logic [mbpr_pkg::POS_W-1:0]           column,
	input  logic signed [mbpr_pkg::RES_W-1:0]    residual,
	input  logic [mbpr_pkg::PIX_W-1:0]           prediction,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mbpr_pkg::PLANE_W-1:0]         plane,
	output logic [mbpr_pkg::ADDR_W-1:0]          address,
	output logic [mbpr_pkg::PIX_W-1:0]           pixel
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int PW    = WW + 1;                   // pitch: width or twice
	localparam int PROD_W = PW + mbpr_pkg::LINE_W;

	// configuration registers
	logic                       field_picture_q;
	logic [mbpr_pkg::CF_W-1:0]  chroma_sampling_q;
	logic [mbpr_pkg::CFG_W-1:0] luma_width_q;
	logic [mbpr_pkg::CFG_W-1:0] chroma_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_picture_q   <= 1'b0;
			chroma_sampling_q <= mbpr_pkg::CF_420;
			luma_width_q      <= mbpr_pkg::LUMA_WIDTH_RST;
			chroma_width_q    <= mbpr_pkg::CHROMA_WIDTH_RST;
		end else if (cfg_wr_en) begin
			case (mbpr_pkg::cfg_reg_t'(cfg_index))
				mbpr_pkg::REG_FIELD_PICTURE:   field_picture_q   <= cfg_data[0];
				mbpr_pkg::REG_CHROMA_SAMPLING:
					chroma_sampling_q <= cfg_data[mbpr_pkg::CF_W-1:0];
				mbpr_pkg::REG_LUMA_WIDTH:      luma_width_q      <= cfg_data;
				mbpr_pkg::REG_CHROMA_WIDTH:    chroma_width_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control: a stage moves when empty or when the next moves
	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: decode and pixel
	mbpr_pkg::addr_terms_t      terms;
	logic [WW-1:0]              width;
	logic [mbpr_pkg::PIX_W-1:0] pix_new;

	mbpr_decode #(
		.MAX_WIDTH(MAX_WIDTH),
		.WW       (WW)
	) u_decode (
		.block_number     (block_number),
		.origin_x         (origin_x),
		.origin_y         (origin_y),
		.dct_field        (dct_field),
		.row              (row),
		.column           (column),
		.field_picture    (field_picture_q),
		.chroma_sampling  (chroma_sampling_q),
		.luma_width       (luma_width_q),
		.chroma_line_width(chroma_width_q),
		.terms            (terms),
		.width            (width)
	);

	mbpr_pixel u_pixel (
		.residual  (residual),
		.prediction(prediction),
		.add_mode  (add_mode),
		.pixel     (pix_new)
	);

	mbpr_pkg::addr_terms_t      terms_s1;
	logic [PW-1:0]              pitch_s1;
	logic [mbpr_pkg::PIX_W-1:0] pixel_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			terms_s1 <= terms;
			pitch_s1 <= terms.dbl_width ? {width, 1'b0} : {1'b0, width};
			pixel_s1 <= pix_new;
		end
	end

	// stage 2: line offset multiply
	logic [PROD_W-1:0]            prod_s2;
	logic [mbpr_pkg::XSUM_W-1:0]  xsum_s2;
	logic [mbpr_pkg::PLANE_W-1:0] plane_s2;
	logic [mbpr_pkg::PIX_W-1:0]   pixel_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			prod_s2  <= PROD_W'(pitch_s1) * PROD_W'(terms_s1.line);
			xsum_s2  <= terms_s1.xsum;
			plane_s2 <= terms_s1.plane;
			pixel_s2 <= pixel_s1;
		end
	end

	// stage 3: final address, output register
	logic [mbpr_pkg::ADDR_W-1:0]  address_s3;
	logic [mbpr_pkg::PLANE_W-1:0] plane_s3;
	logic [mbpr_pkg::PIX_W-1:0]   pixel_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			address_s3 <= mbpr_pkg::ADDR_W'(prod_s2) + mbpr_pkg::ADDR_W'(xsum_s2);
			plane_s3   <= plane_s2;
			pixel_s3   <= pixel_s2;
		end
	end

	assign out_valid = valid_s3;
	assign plane     = plane_s3;
	assign address   = address_s3;
	assign pixel     = pixel_s3;

endmodule

// ===== tb/mpeg_block_pixel_reconstruct_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeg_block_pixel_reconstruct_test
// Self-checking bench for the per-pixel block reconstruction pipeline.
// A scoreboard class recomputes plane, address and clipped pixel for every
// accepted request under the current register settings and checks each
// result in order. Directed edge cases run first at reset settings, then
// randomized requests run through a series of register settings, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module mpeg_block_pixel_reconstruct_test;

	// Unnamed chroma format code, decoded like 4:2:2
	localparam logic [mbpr_pkg::CF_W-1:0] CF_SPARE = 2'd3;
	localparam longint unsigned LINE_MAX = 4096;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 12;
	localparam int PHASE_REQUESTS = 111;

	typedef struct {
		logic [mbpr_pkg::BLK_W-1:0]          blk;
		logic [mbpr_pkg::COORD_W-1:0]        origin_x;
		logic [mbpr_pkg::COORD_W-1:0]        origin_y;
		logic                                dct_field;
		logic                                add_mode;
		logic [mbpr_pkg::POS_W-1:0]          row;
		logic [mbpr_pkg::POS_W-1:0]          column;
		logic signed [mbpr_pkg::RES_W-1:0]   residual;
		logic [mbpr_pkg::PIX_W-1:0]          prediction;
	} pix_req_t;

	typedef struct {
		logic [mbpr_pkg::PLANE_W-1:0] plane;
		logic [mbpr_pkg::ADDR_W-1:0]  address;
		logic [mbpr_pkg::PIX_W-1:0]   pixel;
	} pixel_result_t;

	// Scoreboard: register copy, reconstruction predictor, in-order check
	class pixel_recon_model;
		logic                         field_pic;
		logic [mbpr_pkg::CF_W-1:0]    chroma_fmt;
		logic [mbpr_pkg::CFG_W-1:0]   luma_w;
		logic [mbpr_pkg::CFG_W-1:0]   chroma_w;
		pixel_result_t                expected_pixels[$];
		int                           errors;

		function new();
			field_pic  = 1'b0;
			chroma_fmt = mbpr_pkg::CF_420;
			luma_w     = mbpr_pkg::LUMA_WIDTH_RST;
			chroma_w   = mbpr_pkg::CHROMA_WIDTH_RST;
			errors     = 0;
		endfunction

		// Work out plane, address and pixel for one accepted request
		function void note_request(pix_req_t r);
			longint unsigned w, bx, by, yoff, xoff, pitch, start, full;
			logic lace;
			int sum;
			pixel_result_t e;
			bx = r.origin_x;
			by = r.origin_y;
			if (r.blk < 4) begin
				e.plane = mbpr_pkg::PLANE_Y;
				w = (luma_w > LINE_MAX) ? LINE_MAX : luma_w;
				xoff = r.blk[0] ? 8 : 0;
				lace = !field_pic && r.dct_field;
			end else begin
				e.plane = r.blk[0] ? mbpr_pkg::PLANE_CR : mbpr_pkg::PLANE_CB;
				w = (chroma_w > LINE_MAX) ? LINE_MAX : chroma_w;
				if (chroma_fmt != mbpr_pkg::CF_444) bx = bx >> 1;
				if (chroma_fmt == mbpr_pkg::CF_420) by = by >> 1;
				xoff = r.blk[3] ? 8 : 0;
				lace = !field_pic && r.dct_field && (chroma_fmt != mbpr_pkg::CF_420);
			end
			// field pictures and field-DCT blocks step two lines per row
			if (field_pic) begin
				yoff = r.blk[1] ? 8 : 0;
				pitch = w << 1;
				start = pitch * (by + yoff) + bx + xoff;
			end else if (lace) begin
				yoff = r.blk[1] ? 1 : 0;
				pitch = w << 1;
				start = w * (by + yoff) + bx + xoff;
			end else begin
				yoff = r.blk[1] ? 8 : 0;
				pitch = w;
				start = w * (by + yoff) + bx + xoff;
			end
			full = start + r.row * pitch + r.column;
			e.address = full[mbpr_pkg::ADDR_W-1:0];
			// intra level shift or prediction add, then clip
			sum = int'(r.residual) +
			      (r.add_mode ? int'(r.prediction) : int'(mbpr_pkg::INTRA_OFFSET));
			e.pixel = (sum < 0) ? 8'd0 : (sum > 255) ? 8'd255 : sum[7:0];
			expected_pixels.push_back(e);
		endfunction

		// Compare one accepted result with the oldest outstanding one
		function void check_result(pixel_result_t got);
			pixel_result_t want;
			if (expected_pixels.size() == 0) begin
				$error("unexpected result: plane %0d address 0x%06h pixel %0d",
					got.plane, got.address, got.pixel);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got.plane !== want.plane) begin
				$error("plane: expected %0d, actual %0d", want.plane, got.plane);
				errors++;
			end
			if (got.address !== want.address) begin
				$error("address: expected 0x%06h, actual 0x%06h", want.address, got.address);
				errors++;
			end
			if (got.pixel !== want.pixel) begin
				$error("pixel: expected %0d, actual %0d", want.pixel, got.pixel);
				errors++;
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                cfg_wr_en = 1'b0;
	logic [mbpr_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [mbpr_pkg::CFG_W-1:0]          cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic [mbpr_pkg::BLK_W-1:0]          block_number = '0;
	logic [mbpr_pkg::COORD_W-1:0]        origin_x = '0;
	logic [mbpr_pkg::COORD_W-1:0]        origin_y = '0;
	logic                                dct_field = 1'b0;
	logic                                add_mode = 1'b0;
	logic [mbpr_pkg::POS_W-1:0]          row = '0;
	logic [mbpr_pkg::POS_W-1:0]          column = '0;
	logic signed [mbpr_pkg::RES_W-1:0]   residual = '0;
	logic [mbpr_pkg::PIX_W-1:0]          prediction = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [mbpr_pkg::PLANE_W-1:0]        plane;
	logic [mbpr_pkg::ADDR_W-1:0]         address;
	logic [mbpr_pkg::PIX_W-1:0]          pixel;

	pixel_recon_model model;
	bit quiet = 1'b0;
	int idle_cycles = 0;
	int edge_res[8] = '{-32768, 32767, -129, -128, 127, 128, 0, -1};

	mpeg_block_pixel_reconstruct u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.block_number (block_number),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.dct_field    (dct_field),
		.add_mode     (add_mode),
		.row          (row),
		.column       (column),
		.residual     (residual),
		.prediction   (prediction),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.plane        (plane),
		.address      (address),
		.pixel        (pixel)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stalls except during the quiet phase
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 33);
	end

	// Result monitor
	always @(posedge clk) begin
		pixel_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.plane = plane;
			got.address = address;
			got.pixel = pixel;
			model.check_result(got);
		end
	end

	// Watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one request, with random leading gaps, and hold it until taken
	task automatic send_request(input pix_req_t r);
		while (!quiet && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		block_number <= r.blk;
		origin_x     <= r.origin_x;
		origin_y     <= r.origin_y;
		dct_field    <= r.dct_field;
		add_mode     <= r.add_mode;
		row          <= r.row;
		column       <= r.column;
		residual     <= r.residual;
		prediction   <= r.prediction;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		model.note_request(r);
	endtask

	// Let every outstanding result come out, then idle with no request presented
	task automatic drain();
		in_valid <= 1'b0;
		while (model.expected_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all four registers; the 1-bit and 2-bit ones get junk upper bits
	task automatic set_config(input logic fp, input logic [mbpr_pkg::CF_W-1:0] cf,
			input logic [mbpr_pkg::CFG_W-1:0] lw, input logic [mbpr_pkg::CFG_W-1:0] cw);
		cfg_wr_en <= 1'b1;
		cfg_index <= mbpr_pkg::REG_FIELD_PICTURE;
		cfg_data  <= {(mbpr_pkg::CFG_W - 1)'($urandom_range(4095)), fp};
		@(posedge clk);
		cfg_index <= mbpr_pkg::REG_CHROMA_SAMPLING;
		cfg_data  <= {(mbpr_pkg::CFG_W - mbpr_pkg::CF_W)'($urandom_range(2047)), cf};
		@(posedge clk);
		cfg_index <= mbpr_pkg::REG_LUMA_WIDTH;
		cfg_data  <= lw;
		@(posedge clk);
		cfg_index <= mbpr_pkg::REG_CHROMA_WIDTH;
		cfg_data  <= cw;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model.field_pic  = fp;
		model.chroma_fmt = cf;
		model.luma_w     = lw;
		model.chroma_w   = cw;
	endtask

	function automatic pix_req_t rand_request();
		pix_req_t r;
		r.blk = (mbpr_pkg::BLK_W)'(($urandom_range(99) < 88) ?
			$urandom_range(11) : $urandom_range(15, 12));
		r.origin_x = (mbpr_pkg::COORD_W)'($urandom());
		r.origin_y = (mbpr_pkg::COORD_W)'($urandom());
		r.dct_field = 1'($urandom_range(1));
		r.add_mode = 1'($urandom_range(1));
		r.row = (mbpr_pkg::POS_W)'($urandom());
		r.column = (mbpr_pkg::POS_W)'($urandom());
		// mostly near the clip range, sometimes anywhere in 16 bits
		if ($urandom_range(3) == 0)
			r.residual = (mbpr_pkg::RES_W)'($urandom());
		else
			r.residual = (mbpr_pkg::RES_W)'(int'($urandom_range(639)) - 320);
		r.prediction = (mbpr_pkg::PIX_W)'($urandom());
		return r;
	endfunction

	initial begin
		pix_req_t r;
		model = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge cases at reset settings: every block number, extreme fields
		for (int k = 0; k < 20; k++) begin
			r.blk = k[3:0];
			r.origin_x = k[0] ? 12'hFFF : (mbpr_pkg::COORD_W)'(k * 16);
			r.origin_y = k[1] ? 12'hFFF : 12'h000;
			r.dct_field = k[2];
			r.add_mode = k[0] ^ k[3];
			r.row = k[2:0];
			r.column = ~k[2:0];
			r.residual = (mbpr_pkg::RES_W)'(edge_res[k % 8]);
			r.prediction = k[1] ? 8'hFF : 8'h00;
			send_request(r);
		end

		// Register settings: extremes first, then random ones
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: set_config(1'b1, mbpr_pkg::CF_422, 13'd16, 13'd8);
				1: set_config(1'b0, mbpr_pkg::CF_444, 13'd4096, 13'd4096);
				2: set_config(1'b0, CF_SPARE, 13'd8191, 13'd8191);
				3: set_config(1'b1, mbpr_pkg::CF_420, 13'd0, 13'd0);
				4: set_config(1'b0, mbpr_pkg::CF_420, 13'd4097, 13'd4095);
				default: begin
					set_config(1'($urandom_range(1)),
						(mbpr_pkg::CF_W)'($urandom_range(3)),
						(mbpr_pkg::CFG_W)'($urandom_range(8191)),
						(mbpr_pkg::CFG_W)'($urandom_range(8191)));
				end
			endcase
			quiet = (p == 5);
			for (int n = 0; n < PHASE_REQUESTS; n++) send_request(rand_request());
		end

		drain();
		if (model.expected_pixels.size() != 0) begin
			$error("%0d results never arrived", model.expected_pixels.size());
			model.errors++;
		end
		if (model.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/mbpr_pkg.sv
src/mbpr_decode.sv
src/mbpr_pixel.sv
src/mpeg_block_pixel_reconstruct.sv
tb/mpeg_block_pixel_reconstruct_test.sv
